### hdl/otg_pkg.sv
// Shared constants for the overlapping tile generator: register map and APB address width.
`default_nettype none

package otg_pkg;

  localparam int REG_COUNT = 6;
  localparam int ADDR_BITS = $clog2(4 * REG_COUNT);

  typedef logic [ADDR_BITS-3:0] reg_idx_t;

  localparam reg_idx_t REG_IMAGE_WIDTH  = reg_idx_t'(0);
  localparam reg_idx_t REG_IMAGE_HEIGHT = reg_idx_t'(1);
  localparam reg_idx_t REG_SLICE_WIDTH  = reg_idx_t'(2);
  localparam reg_idx_t REG_SLICE_HEIGHT = reg_idx_t'(3);
  localparam reg_idx_t REG_OVERLAP_X    = reg_idx_t'(4);
  localparam reg_idx_t REG_OVERLAP_Y    = reg_idx_t'(5);

endpackage

`default_nettype wire

### hdl/overlapping_tile_generator.sv
// Top level of the overlapping tile generator: tile state, placement and output stage.
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ---------------------------------------------
//  in       sink       in_valid / in_stall   restart
//  out      source     out_valid / out_stall tile_x tile_y tile_width tile_height
//                                            row_end frame_end
//  cfg      APB slave  psel penable pready   paddr pwdata prdata (reg i at byte 4*i)
//
// One tile per cycle while in_stall is low: a request transaction becomes a tile in
// the cycle it is accepted and is registered into the output register, or into the
// skid entry if a held output is stalled. The output register plus one skid entry
// decouple the two sides: in_stall rises only when both hold a tile, in the cycle
// after an output stall meets a new transaction. rst (synchronous) clears the tile
// position to (0,0), empties the output stage and loads the register reset values.
`default_nettype none

module overlapping_tile_generator
  import otg_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  restart,
  // tile channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [COORD_BITS-1:0] tile_x,
  output logic      [COORD_BITS-1:0] tile_y,
  output logic      [COORD_BITS:0]   tile_width,
  output logic      [COORD_BITS:0]   tile_height,
  output logic                       row_end,
  output logic                       frame_end,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int PAY_BITS = 2 * COORD_BITS + 2 * (COORD_BITS + 1) + 2;

  logic [COORD_BITS:0]   img_w;
  logic [COORD_BITS:0]   img_h;
  logic [COORD_BITS:0]   slc_w;
  logic [COORD_BITS:0]   slc_h;
  logic [COORD_BITS-1:0] overlap_x;
  logic [COORD_BITS-1:0] overlap_y;

  // tile position state
  logic [COORD_BITS-1:0] col_start;
  logic [COORD_BITS-1:0] row_start;

  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] org_x;
  logic [COORD_BITS-1:0] org_y;
  logic [COORD_BITS:0]   len_x;
  logic [COORD_BITS:0]   len_y;
  logic                  hit_x;
  logic                  hit_y;
  logic [COORD_BITS-1:0] next_x;
  logic [COORD_BITS-1:0] next_y;
  logic                  last_tile;
  logic                  accept;
  logic                  skid_full;
  logic [PAY_BITS-1:0]   tile_pay;
  logic [PAY_BITS-1:0]   out_pay;

  assign pready = 1'b1;

  otg_regs #(.COORD_BITS(COORD_BITS)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .img_w     (img_w),
    .img_h     (img_h),
    .slc_w     (slc_w),
    .slc_h     (slc_h),
    .overlap_x (overlap_x),
    .overlap_y (overlap_y)
  );

  // restart forces the top-left tile for this transaction
  assign start_x = restart ? '0 : col_start;
  assign start_y = restart ? '0 : row_start;

  otg_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .start       (start_x),
    .size_raw    (slc_w),
    .extent_raw  (img_w),
    .overlap_raw (overlap_x),
    .origin      (org_x),
    .length      (len_x),
    .edge_hit    (hit_x),
    .next_start  (next_x)
  );

  otg_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .start       (start_y),
    .size_raw    (slc_h),
    .extent_raw  (img_h),
    .overlap_raw (overlap_y),
    .origin      (org_y),
    .length      (len_y),
    .edge_hit    (hit_y),
    .next_start  (next_y)
  );

  assign last_tile = hit_x && hit_y;
  assign in_stall  = skid_full;
  assign accept    = in_valid && !in_stall;

  // advance in raster order; wrap to (0,0) after the last tile of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col_start <= '0;
      row_start <= '0;
    end else if (accept) begin
      if (!hit_x) begin
        col_start <= next_x;
        row_start <= start_y;
      end else begin
        col_start <= '0;
        row_start <= last_tile ? '0 : next_y;
      end
    end
  end

  assign tile_pay = {org_x, org_y, len_x, len_y, hit_x, last_tile};

  otg_skid #(.WIDTH(PAY_BITS)) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (tile_pay),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_pay)
  );

  assign {tile_x, tile_y, tile_width, tile_height, row_end, frame_end} = out_pay;

endmodule

`default_nettype wire

### hdl/otg_regs.sv
// APB configuration register file for the tile generator.
`default_nettype none

module otg_regs
  import otg_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic      [COORD_BITS:0]   img_w,
  output logic      [COORD_BITS:0]   img_h,
  output logic      [COORD_BITS:0]   slc_w,
  output logic      [COORD_BITS:0]   slc_h,
  output logic      [COORD_BITS-1:0] overlap_x,
  output logic      [COORD_BITS-1:0] overlap_y
);

  localparam int SB = COORD_BITS + 1;

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = paddr[ADDR_BITS-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w     <= SB'(1920);
      img_h     <= SB'(1080);
      slc_w     <= SB'(640);
      slc_h     <= SB'(640);
      overlap_x <= COORD_BITS'(128);
      overlap_y <= COORD_BITS'(128);
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:  img_w     <= pwdata[COORD_BITS:0];
        REG_IMAGE_HEIGHT: img_h     <= pwdata[COORD_BITS:0];
        REG_SLICE_WIDTH:  slc_w     <= pwdata[COORD_BITS:0];
        REG_SLICE_HEIGHT: slc_h     <= pwdata[COORD_BITS:0];
        REG_OVERLAP_X:    overlap_x <= pwdata[COORD_BITS-1:0];
        REG_OVERLAP_Y:    overlap_y <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = 32'(img_w);
      REG_IMAGE_HEIGHT: prdata = 32'(img_h);
      REG_SLICE_WIDTH:  prdata = 32'(slc_w);
      REG_SLICE_HEIGHT: prdata = 32'(slc_h);
      REG_OVERLAP_X:    prdata = 32'(overlap_x);
      REG_OVERLAP_Y:    prdata = 32'(overlap_y);
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/otg_axis.sv
// One axis of tile placement: size fixup, edge pull-back and next start.
`default_nettype none

module otg_axis #(
  parameter int COORD_BITS = 13
) (
  input  wire logic [COORD_BITS-1:0] start,
  input  wire logic [COORD_BITS:0]   size_raw,
  input  wire logic [COORD_BITS:0]   extent_raw,
  input  wire logic [COORD_BITS-1:0] overlap_raw,
  output logic      [COORD_BITS-1:0] origin,
  output logic      [COORD_BITS:0]   length,
  output logic                       edge_hit,
  output logic      [COORD_BITS-1:0] next_start
);

  localparam int SB = COORD_BITS + 1;
  localparam logic [COORD_BITS:0] DIM_MAX = SB'(1) << COORD_BITS;

  logic [COORD_BITS:0] size;
  logic [COORD_BITS:0] extent;
  logic [COORD_BITS:0] ovl;
  logic [COORD_BITS:0] step;
  logic [COORD_BITS:0] stop_pos;
  logic [COORD_BITS:0] org;
  logic [COORD_BITS:0] end_pos;
  logic [COORD_BITS:0] adv;

  // zero reads as one, anything past 2^COORD_BITS saturates
  function automatic logic [COORD_BITS:0] fix_size(input logic [COORD_BITS:0] v);
    if (v == '0)
      return SB'(1);
    else if (v > DIM_MAX)
      return DIM_MAX;
    else
      return v;
  endfunction

  always_comb begin
    size   = fix_size(size_raw);
    extent = fix_size(extent_raw);
    ovl    = (SB'(overlap_raw) >= size) ? size - SB'(1) : SB'(overlap_raw);
    step   = size - ovl;

    end_pos  = SB'(start) + size;
    stop_pos = (end_pos < extent) ? end_pos : extent;
    org      = (stop_pos > size) ? stop_pos - size : '0;

    origin   = org[COORD_BITS-1:0];
    length   = stop_pos - org;
    edge_hit = (end_pos >= extent);

    adv        = SB'(start) + step;
    next_start = adv[COORD_BITS-1:0];
  end

endmodule

`default_nettype wire

### hdl/otg_skid.sv
// Output register with one skid entry so the input side can place one more item while the output is stalled.
`default_nettype none

module otg_skid #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [WIDTH-1:0] load_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] skid_data;
  logic             skid_valid;
  logic             drain;

  assign full  = skid_valid;
  assign drain = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || load;
      skid_valid <= 1'b0;
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid)
        out_data <= skid_data;
      else if (load)
        out_data <= load_data;
    end else if (load) begin
      skid_data <= load_data;
    end
  end

endmodule

`default_nettype wire

### hdl/otg_checker.sv
// Port-level assertions for the tile generator, bound to the top level.
`default_nettype none

module otg_checker #(
  parameter int COORD_BITS = 13
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] tile_x,
  input wire logic [COORD_BITS-1:0] tile_y,
  input wire logic [COORD_BITS:0]   tile_width,
  input wire logic [COORD_BITS:0]   tile_height,
  input wire logic                  row_end,
  input wire logic                  frame_end
);

  // a stalled tile holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tile_x) && $stable(tile_y) &&
      $stable(tile_width) && $stable(tile_height) && $stable(row_end) && $stable(frame_end))
    else $error("stalled tile changed");

  // the frame always closes on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame_end without row_end");

  a_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tile_width != '0 && tile_height != '0)
    else $error("zero tile size");

  // skid entry only fills behind a held output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("accepted request produced no tile");

endmodule

bind overlapping_tile_generator otg_checker #(.COORD_BITS(COORD_BITS)) u_otg_checker (.*);

`default_nettype wire
